/* design/rpt_pkg.sv */
package rpt_pkg;

    // Field and register widths
    localparam int unsigned CMD_W      = 3;
    localparam int unsigned CNT_W      = 64;
    localparam int unsigned BYTES_W    = 32;
    localparam int unsigned TRY_W      = 40;
    localparam int unsigned ZONE_W     = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRY_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TARGET  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_START      = 3'd0,
        CMD_END_STEP   = 3'd1,
        CMD_ZONE_BEGIN = 3'd2,
        CMD_ZONE_END   = 3'd3,
        CMD_ADD_BYTES  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2,
        PH_ERR  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_NOT_READY  = 2'd1,
        ERR_UNBALANCED = 2'd2,
        ERR_BYTES      = 2'd3
    } err_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CNT_W-1:0]   now_cycles;
        logic [CNT_W-1:0]   fault_reading;
        logic [BYTES_W-1:0] byte_amount;
        logic               counters_ready;
    } in_data_t;

    typedef struct packed {
        logic             running;
        logic [1:0]       run_state;
        logic [1:0]       error_code;
        logic [CNT_W-1:0] min_cycles;
        logic [CNT_W-1:0] min_faults;
        logic [CNT_W-1:0] max_cycles;
        logic [CNT_W-1:0] max_faults;
        logic [CNT_W-1:0] total_cycles;
        logic [CNT_W-1:0] total_bytes;
        logic [CNT_W-1:0] total_faults;
        logic [CNT_W-1:0] total_steps;
    } out_data_t;

endpackage

/* design/rpt_if.sv */
interface rpt_in_if;
    logic               valid;
    logic               ready;
    rpt_pkg::in_data_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rpt_out_if;
    logic               valid;
    logic               ready;
    rpt_pkg::out_data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/repetition_perf_tracker.sv */
// Repetition performance tracker.
// in_ch carries event requests (start run, end step, zone begin/end, add
// bytes); out_ch returns one result per request: run state, error code,
// the fastest and slowest step snapshots and the running totals.
// cfg_we/cfg_index/cfg_data write the try duration (index 0) and the
// per-step byte target (index 1); write them only while no request is in flight.
// A request is captured in an input register, then its adds and compares
// update the tracker state, which doubles as the result register. A result
// is valid once its request has passed the input and state registers, and
// one request is taken per cycle while results are drained. The 64-bit
// elapsed-time subtract and compare on end step sets the cycle time.
// Reset clears the state to idle, all totals and snapshots to zero (empty
// minimum) and both configuration registers to zero.
// When the receiver stalls, the result holds; the input register still
// takes one more request, after which in_ch.ready drops until the result
// is taken.
module repetition_perf_tracker #(
    parameter logic [39:0] DEFAULT_DURATION = 40'd240000000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rpt_in_if.sink                              in_ch,
    rpt_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [rpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned CW = rpt_pkg::CNT_W;

    // Configuration
    logic [rpt_pkg::TRY_W-1:0]   try_duration_reg;
    logic [rpt_pkg::BYTES_W-1:0] byte_target_reg;

    // Pipeline control and input register
    logic              in_valid_reg;
    rpt_pkg::in_data_t in_data_reg;
    logic              out_valid_reg;
    logic              advance;

    // Tracker state
    rpt_pkg::phase_t     phase_reg, phase_next;
    rpt_pkg::err_t       err_reg, err_next;
    logic [CW-1:0]       window_reg, window_next;
    logic [rpt_pkg::ZONE_W-1:0] zones_reg, zones_next;
    logic [CW-1:0]       step_cyc_reg, step_cyc_next;
    logic [CW-1:0]       step_bytes_reg, step_bytes_next;
    logic [CW-1:0]       step_flt_reg, step_flt_next;
    logic [CW-1:0]       tot_cyc_reg, tot_cyc_next;
    logic [CW-1:0]       tot_bytes_reg, tot_bytes_next;
    logic [CW-1:0]       tot_flt_reg, tot_flt_next;
    logic [CW-1:0]       tot_steps_reg, tot_steps_next;
    logic [CW-1:0]       minp1_cyc_reg, minp1_cyc_next;
    logic [CW-1:0]       min_flt_reg, min_flt_next;
    logic [CW-1:0]       max_cyc_reg, max_cyc_next;
    logic [CW-1:0]       max_flt_reg, max_flt_next;

    // End-step helpers
    logic                      new_min;
    logic [rpt_pkg::TRY_W-1:0] duration;
    logic [CW-1:0]             elapsed;

    // Move the held request into the result stage when the result slot frees
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;

    // Capture configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            try_duration_reg <= '0;
            byte_target_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpt_pkg::CFG_TRY_DURATION:
                    try_duration_reg <= cfg_data[rpt_pkg::TRY_W-1:0];
                rpt_pkg::CFG_BYTE_TARGET:
                    byte_target_reg <= cfg_data[rpt_pkg::BYTES_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_data_reg <= in_ch.data;
    end

    assign duration = (try_duration_reg == '0) ? DEFAULT_DURATION : try_duration_reg;
    assign elapsed  = in_data_reg.now_cycles - window_reg;
    assign new_min  = (minp1_cyc_reg - CW'(1)) > step_cyc_reg;

    // Work out the state after the held request
    always_comb
    begin
        phase_next      = phase_reg;
        err_next        = err_reg;
        window_next     = window_reg;
        zones_next      = zones_reg;
        step_cyc_next   = step_cyc_reg;
        step_bytes_next = step_bytes_reg;
        step_flt_next   = step_flt_reg;
        tot_cyc_next    = tot_cyc_reg;
        tot_bytes_next  = tot_bytes_reg;
        tot_flt_next    = tot_flt_reg;
        tot_steps_next  = tot_steps_reg;
        minp1_cyc_next  = minp1_cyc_reg;
        min_flt_next    = min_flt_reg;
        max_cyc_next    = max_cyc_reg;
        max_flt_next    = max_flt_reg;

        case (in_data_reg.command)
            rpt_pkg::CMD_START:
            begin
                step_cyc_next   = '0;
                step_bytes_next = '0;
                step_flt_next   = '0;
                zones_next      = '0;
                window_next     = in_data_reg.now_cycles;
                if (in_data_reg.counters_ready)
                begin
                    phase_next = rpt_pkg::PH_RUN;
                    err_next   = rpt_pkg::ERR_NONE;
                end
                else
                begin
                    phase_next = rpt_pkg::PH_ERR;
                    err_next   = rpt_pkg::ERR_NOT_READY;
                end
            end
            rpt_pkg::CMD_END_STEP:
            begin
                if (phase_reg == rpt_pkg::PH_RUN)
                begin
                    if (zones_reg != '0)
                    begin
                        // unbalanced zones: keep the step as it is
                        phase_next = rpt_pkg::PH_ERR;
                        err_next   = rpt_pkg::ERR_UNBALANCED;
                    end
                    else
                    begin
                        // fold the step into the totals
                        tot_cyc_next   = tot_cyc_reg + step_cyc_reg;
                        tot_bytes_next = tot_bytes_reg + step_bytes_reg;
                        tot_flt_next   = tot_flt_reg + step_flt_reg;
                        tot_steps_next = tot_steps_reg + CW'(1);
                        // snapshot a new fastest step and restart the window
                        if (new_min)
                        begin
                            minp1_cyc_next = step_cyc_reg + CW'(1);
                            min_flt_next   = step_flt_reg;
                            window_next    = in_data_reg.now_cycles;
                        end
                        if (max_cyc_reg < step_cyc_reg)
                        begin
                            max_cyc_next = step_cyc_reg;
                            max_flt_next = step_flt_reg;
                        end
                        if ((byte_target_reg != '0) &&
                            ({{(CW-rpt_pkg::BYTES_W){1'b0}}, byte_target_reg}
                             != step_bytes_reg))
                        begin
                            phase_next = rpt_pkg::PH_ERR;
                            err_next   = rpt_pkg::ERR_BYTES;
                        end
                        step_cyc_next   = '0;
                        step_bytes_next = '0;
                        step_flt_next   = '0;
                        // complete once no new minimum for the try duration
                        if (!new_min &&
                            (elapsed > {{(CW-rpt_pkg::TRY_W){1'b0}}, duration}))
                            phase_next = rpt_pkg::PH_DONE;
                    end
                end
            end
            rpt_pkg::CMD_ZONE_BEGIN:
            begin
                zones_next    = zones_reg + rpt_pkg::ZONE_W'(1);
                step_cyc_next = step_cyc_reg - in_data_reg.now_cycles;
                step_flt_next = step_flt_reg - in_data_reg.fault_reading;
            end
            rpt_pkg::CMD_ZONE_END:
            begin
                zones_next    = zones_reg - rpt_pkg::ZONE_W'(1);
                step_cyc_next = step_cyc_reg + in_data_reg.now_cycles;
                step_flt_next = step_flt_reg + in_data_reg.fault_reading;
            end
            rpt_pkg::CMD_ADD_BYTES:
            begin
                step_bytes_next = step_bytes_reg +
                    {{(CW-rpt_pkg::BYTES_W){1'b0}}, in_data_reg.byte_amount};
            end
            default:
                ;
        endcase
    end

    // Update the state, which also forms the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rpt_pkg::PH_IDLE;
            err_reg        <= rpt_pkg::ERR_NONE;
            window_reg     <= '0;
            zones_reg      <= '0;
            step_cyc_reg   <= '0;
            step_bytes_reg <= '0;
            step_flt_reg   <= '0;
            tot_cyc_reg    <= '0;
            tot_bytes_reg  <= '0;
            tot_flt_reg    <= '0;
            tot_steps_reg  <= '0;
            minp1_cyc_reg  <= '0;
            min_flt_reg    <= '0;
            max_cyc_reg    <= '0;
            max_flt_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            err_reg        <= err_next;
            window_reg     <= window_next;
            zones_reg      <= zones_next;
            step_cyc_reg   <= step_cyc_next;
            step_bytes_reg <= step_bytes_next;
            step_flt_reg   <= step_flt_next;
            tot_cyc_reg    <= tot_cyc_next;
            tot_bytes_reg  <= tot_bytes_next;
            tot_flt_reg    <= tot_flt_next;
            tot_steps_reg  <= tot_steps_next;
            minp1_cyc_reg  <= minp1_cyc_next;
            min_flt_reg    <= min_flt_next;
            max_cyc_reg    <= max_cyc_next;
            max_flt_reg    <= max_flt_next;
        end
    end

    // Drive the result from the state
    assign out_ch.data.running      = (phase_reg == rpt_pkg::PH_RUN);
    assign out_ch.data.run_state    = phase_reg;
    assign out_ch.data.error_code   = err_reg;
    assign out_ch.data.min_cycles   = minp1_cyc_reg - CW'(1);
    assign out_ch.data.min_faults   = min_flt_reg;
    assign out_ch.data.max_cycles   = max_cyc_reg;
    assign out_ch.data.max_faults   = max_flt_reg;
    assign out_ch.data.total_cycles = tot_cyc_reg;
    assign out_ch.data.total_bytes  = tot_bytes_reg;
    assign out_ch.data.total_faults = tot_flt_reg;
    assign out_ch.data.total_steps  = tot_steps_reg;

    // Stats move only when a request reaches the result stage
    a_stats_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tot_steps_reg) && $stable(minp1_cyc_reg))
        else $error("stats changed without a request");

    // A stalled input always has a request waiting in the input register
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with an empty pipeline");

    // A start leaves no open zones and a running or failed run
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_data_reg.command == rpt_pkg::CMD_START) |=>
        (zones_reg == '0) &&
        ((phase_reg == rpt_pkg::PH_RUN) || (phase_reg == rpt_pkg::PH_ERR)))
        else $error("start did not reset the run");

    // A recorded minimum implies at least one folded step
    a_min_has_step: assert property (@(posedge clk) disable iff (!rst_n)
        (minp1_cyc_reg != '0) |-> (tot_steps_reg != '0))
        else $error("minimum recorded without any step");

endmodule
